/* hdl/pointer_accel_clamp_tracker_unit_assert.svh */
// Assertion macros for the pointer tracker.
// Included by the top level; needs no other file.
`ifndef POINTER_ACCEL_CLAMP_TRACKER_UNIT_ASSERT_SVH
`define POINTER_ACCEL_CLAMP_TRACKER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PACCT_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define PACCT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PACCT_ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define PACCT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

/* hdl/pacct_pkg.sv */
// Shared constants, codes and types of the pointer tracker.
// No dependencies.
package pacct_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int KIND_W      = 2;
    localparam int DELTA_W     = 9;
    localparam int BTN_W       = 3;
    localparam int POS_REQ_W   = 14;
    localparam int SCALE_W     = 5;
    localparam int THRESH_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = COORD_WIDTH;

    // accelerated magnitude: |delta| up to 2^(DELTA_W-1)
    localparam int MAG_W  = DELTA_W + 1;
    localparam int ACC_W  = MAG_W + SCALE_W;
    // signed working width for position arithmetic
    localparam int BASE_W = (COORD_WIDTH > ACC_W) ? COORD_WIDTH : ACC_W;
    localparam int CALC_W = ((BASE_W > POS_REQ_W) ? BASE_W : POS_REQ_W) + 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CENTER = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd5;

    // reset values
    localparam logic [COORD_WIDTH-1:0] MIN_X_RST  = COORD_WIDTH'(0);
    localparam logic [COORD_WIDTH-1:0] MAX_X_RST  = COORD_WIDTH'(1024);
    localparam logic [COORD_WIDTH-1:0] MIN_Y_RST  = COORD_WIDTH'(0);
    localparam logic [COORD_WIDTH-1:0] MAX_Y_RST  = COORD_WIDTH'(768);
    localparam logic [SCALE_W-1:0]     SCALE_RST  = SCALE_W'(2);
    localparam logic [THRESH_W-1:0]    THRESH_RST = THRESH_W'(5);

    typedef struct packed {
        logic [COORD_WIDTH-1:0] min_x;
        logic [COORD_WIDTH-1:0] max_x;
        logic [COORD_WIDTH-1:0] min_y;
        logic [COORD_WIDTH-1:0] max_y;
        logic [SCALE_W-1:0]     scale;
        logic [THRESH_W-1:0]    thresh;
    } cfg_t;

    // settings seen by one axis
    typedef struct packed {
        logic [COORD_WIDTH-1:0] lo;
        logic [COORD_WIDTH-1:0] hi;
        logic [SCALE_W-1:0]     scale;
        logic [THRESH_W-1:0]    thresh;
    } axis_cfg_t;

endpackage

/* hdl/pacct_if.sv */
// Channel interfaces of the pointer tracker: command words in, position words out.
// Depends on pacct_pkg.
interface pacct_cmd_if;
    import pacct_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           kind;
    logic signed [DELTA_W-1:0]   delta_x;
    logic signed [DELTA_W-1:0]   delta_y;
    logic [BTN_W-1:0]            button_bits;
    logic signed [POS_REQ_W-1:0] new_x;
    logic signed [POS_REQ_W-1:0] new_y;

    modport source (output valid, kind, delta_x, delta_y, button_bits, new_x, new_y,
                    input ready);
    modport sink   (input valid, kind, delta_x, delta_y, button_bits, new_x, new_y,
                    output ready);
endinterface

interface pacct_res_if;
    import pacct_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] pos_x;
    logic [COORD_WIDTH-1:0] pos_y;
    logic [BTN_W-1:0]       buttons;

    modport source (output valid, pos_x, pos_y, buttons, input ready);
    modport sink   (input valid, pos_x, pos_y, buttons, output ready);
endinterface

/* hdl/pacct_cfg_regs.sv */
// Configuration register file of the pointer tracker (write only).
// Depends on pacct_pkg.
module pacct_cfg_regs
    import pacct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MIN_X:  cfg_next.min_x  = cfg_wdata[COORD_WIDTH-1:0];
                REG_MAX_X:  cfg_next.max_x  = cfg_wdata[COORD_WIDTH-1:0];
                REG_MIN_Y:  cfg_next.min_y  = cfg_wdata[COORD_WIDTH-1:0];
                REG_MAX_Y:  cfg_next.max_y  = cfg_wdata[COORD_WIDTH-1:0];
                REG_SCALE:  cfg_next.scale  = cfg_wdata[SCALE_W-1:0];
                REG_THRESH: cfg_next.thresh = cfg_wdata[THRESH_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_x  <= MIN_X_RST;
            cfg_reg.max_x  <= MAX_X_RST;
            cfg_reg.min_y  <= MIN_Y_RST;
            cfg_reg.max_y  <= MAX_Y_RST;
            cfg_reg.scale  <= SCALE_RST;
            cfg_reg.thresh <= THRESH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/pacct_axis.sv */
// Next-position logic for one axis: acceleration, accumulate, set, recenter, clamp.
// Depends on pacct_pkg.
module pacct_axis
    import pacct_pkg::*;
(
    input  logic [KIND_W-1:0]           kind,
    input  logic signed [DELTA_W-1:0]   delta,
    input  logic signed [POS_REQ_W-1:0] req_pos,
    input  logic [COORD_WIDTH-1:0]      cur,
    input  axis_cfg_t                   acfg,
    output logic [COORD_WIDTH-1:0]      nxt
);

    // raise to lo first, then lower to hi
    function automatic logic [COORD_WIDTH-1:0] clamp_pos(
        input logic signed [CALC_W-1:0] v,
        input logic [COORD_WIDTH-1:0]   lo,
        input logic [COORD_WIDTH-1:0]   hi
    );
        logic signed [CALC_W-1:0] lo_s;
        logic signed [CALC_W-1:0] hi_s;
        logic signed [CALC_W-1:0] r;
        lo_s = $signed({{(CALC_W-COORD_WIDTH){1'b0}}, lo});
        hi_s = $signed({{(CALC_W-COORD_WIDTH){1'b0}}, hi});
        r    = v;
        if (r < lo_s)
            r = lo_s;
        if (r > hi_s)
            r = hi_s;
        return r[COORD_WIDTH-1:0];
    endfunction

    logic                     neg;
    logic [MAG_W-1:0]         dext;
    logic [MAG_W-1:0]         mag;
    logic [MAG_W-1:0]         thr_ext;
    logic [MAG_W-1:0]         excess;
    logic [ACC_W-1:0]         prod;
    logic [ACC_W-1:0]         acc_mag;
    logic signed [CALC_W-1:0] acc_mag_s;
    logic signed [CALC_W-1:0] acc_delta;
    logic signed [CALC_W-1:0] cur_s;
    logic signed [CALC_W-1:0] moved;
    logic signed [CALC_W-1:0] req_s;
    logic [COORD_WIDTH:0]     mid_sum;
    logic signed [CALC_W-1:0] mid_s;

    // threshold acceleration on the magnitude, sign restored after
    assign neg       = delta[DELTA_W-1];
    assign dext      = {delta[DELTA_W-1], delta};
    assign mag       = neg ? (~dext + MAG_W'(1)) : dext;
    assign thr_ext   = MAG_W'(acfg.thresh);
    assign excess    = mag - thr_ext;
    assign prod      = ACC_W'(excess) * ACC_W'(acfg.scale);
    assign acc_mag   = (mag > thr_ext) ? (ACC_W'(acfg.thresh) + prod) : ACC_W'(mag);
    assign acc_mag_s = $signed({{(CALC_W-ACC_W){1'b0}}, acc_mag});
    assign acc_delta = neg ? -acc_mag_s : acc_mag_s;

    assign cur_s  = $signed({{(CALC_W-COORD_WIDTH){1'b0}}, cur});
    assign moved  = cur_s + acc_delta;

    // requested position, sign extended
    assign req_s  = $signed({{(CALC_W-POS_REQ_W){req_pos[POS_REQ_W-1]}}, req_pos});

    // window middle, rounded down
    assign mid_sum = {1'b0, acfg.lo} + {1'b0, acfg.hi};
    assign mid_s   = $signed({{(CALC_W-COORD_WIDTH){1'b0}}, mid_sum[COORD_WIDTH:1]});

    always_comb
    begin
        case (kind)
            KIND_MOVE:   nxt = clamp_pos(moved, acfg.lo, acfg.hi);
            KIND_SET:    nxt = clamp_pos(req_s, acfg.lo, acfg.hi);
            KIND_CENTER: nxt = clamp_pos(mid_s, acfg.lo, acfg.hi);
            default:     nxt = cur;
        endcase
    end

endmodule

/* hdl/pointer_accel_clamp_tracker_unit.sv */
// Pointer position tracker with threshold acceleration and window clamp (top level).
// Depends on pacct_pkg, pacct_if, pacct_cfg_regs, pacct_axis and the assertion header.
//
// Usage:
//   cmd  : command words (motion report, set position, recenter), valid/ready.
//   res  : one position word per command: pos_x, pos_y, buttons, valid/ready.
//   cfg_*: write-only register port (window limits, scale, threshold);
//          write only while no command is in flight.
// Timing: a command is captured in an input register, the next position is
//   formed by one pass of accelerate/add/clamp logic, and the result lands in
//   the position registers, which drive res directly. res.valid rises after
//   the command has passed both of these registers; one command per cycle is
//   sustained while res.ready stays high.
// Stall: while res is held off, the input register keeps one command and
//   cmd.ready drops once it is full; nothing is lost or repeated.
// Reset: position and buttons clear to zero, registers take their defaults,
//   both channels come up empty.
`include "pointer_accel_clamp_tracker_unit_assert.svh"

module pointer_accel_clamp_tracker_unit
    import pacct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pacct_cmd_if.sink             cmd,
    pacct_res_if.source           res,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg;

    logic                        in_vld_reg;
    logic [KIND_W-1:0]           in_kind_reg;
    logic signed [DELTA_W-1:0]   in_dx_reg;
    logic signed [DELTA_W-1:0]   in_dy_reg;
    logic [BTN_W-1:0]            in_btn_reg;
    logic signed [POS_REQ_W-1:0] in_nx_reg;
    logic signed [POS_REQ_W-1:0] in_ny_reg;

    logic                        out_vld_reg;
    logic                        out_vld_next;
    logic [COORD_WIDTH-1:0]      cur_x_reg;
    logic [COORD_WIDTH-1:0]      cur_y_reg;
    logic [BTN_W-1:0]            btn_reg;
    logic [COORD_WIDTH-1:0]      cur_x_next;
    logic [COORD_WIDTH-1:0]      cur_y_next;
    logic [BTN_W-1:0]            btn_next;

    logic                        adv;
    logic                        adv_move;
    logic                        take;
    axis_cfg_t                   cfg_xa;
    axis_cfg_t                   cfg_ya;

    pacct_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // handshake: move a word forward when the result slot is free or draining
    assign adv       = in_vld_reg && (!out_vld_reg || res.ready);
    assign cmd.ready = !in_vld_reg || adv;
    assign take      = cmd.valid && cmd.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (cmd.ready)
            in_vld_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_kind_reg <= cmd.kind;
            in_dx_reg   <= cmd.delta_x;
            in_dy_reg   <= cmd.delta_y;
            in_btn_reg  <= cmd.button_bits;
            in_nx_reg   <= cmd.new_x;
            in_ny_reg   <= cmd.new_y;
        end
    end

    // per-axis settings
    assign cfg_xa = '{lo: cfg.min_x, hi: cfg.max_x, scale: cfg.scale, thresh: cfg.thresh};
    assign cfg_ya = '{lo: cfg.min_y, hi: cfg.max_y, scale: cfg.scale, thresh: cfg.thresh};

    pacct_axis u_axis_x (
        .kind    (in_kind_reg),
        .delta   (in_dx_reg),
        .req_pos (in_nx_reg),
        .cur     (cur_x_reg),
        .acfg    (cfg_xa),
        .nxt     (cur_x_next)
    );

    pacct_axis u_axis_y (
        .kind    (in_kind_reg),
        .delta   (in_dy_reg),
        .req_pos (in_ny_reg),
        .cur     (cur_y_reg),
        .acfg    (cfg_ya),
        .nxt     (cur_y_next)
    );

    // buttons follow motion reports only
    assign btn_next = (in_kind_reg == KIND_MOVE) ? in_btn_reg : btn_reg;
    assign adv_move = adv && (in_kind_reg == KIND_MOVE);

    assign out_vld_next = adv || (out_vld_reg && !res.ready);

    // state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            btn_reg     <= '0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (adv)
            begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
                btn_reg   <= btn_next;
            end
        end
    end

    assign res.valid   = out_vld_reg;
    assign res.pos_x   = cur_x_reg;
    assign res.pos_y   = cur_y_reg;
    assign res.buttons = btn_reg;

    // checks
    `PACCT_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, adv, out_vld_reg)
    `PACCT_ASSERT_IMPL(a_no_adv_on_stall, clk, rst_n, out_vld_reg && !res.ready, !adv)
    `PACCT_ASSERT_NEXT(a_move_loads_btn, clk, rst_n, adv_move, btn_reg == $past(in_btn_reg))
    `PACCT_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !in_vld_reg, cmd.ready)

endmodule
